FILE: rtl/core/kmh_pkg.sv
// kmh_pkg: shared types and constants for the k-way merge min-heap core.
// Node layout, operation codes, register map and defaults.
// No dependencies.
`timescale 1ns / 1ps

package kmh_pkg;

    localparam int KEY_W   = 32;
    localparam int WAY_W   = 7;
    localparam int SLOT_W  = 7;
    localparam int FUNC_W  = 2;
    localparam int HSIZE_W = 8;
    localparam int APB_AW  = 3;
    localparam int APB_DW  = 32;

    localparam int WAYS_DEF = 128;

    localparam logic [HSIZE_W-1:0] WAY_CNT_RST = 8'd128;

    // operation codes
    localparam logic [FUNC_W-1:0] FN_WRITE   = 2'd0;
    localparam logic [FUNC_W-1:0] FN_BUILD   = 2'd1;
    localparam logic [FUNC_W-1:0] FN_REPLACE = 2'd2;

    // register byte addresses
    localparam logic [APB_AW-1:0] ADDR_WAY_CNT = 3'd0;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [WAY_W-1:0] way;
    } node_t;

endpackage

FILE: rtl/core/kmh_cell.sv
// kmh_cell: one heap level. Holds the level's nodes as sibling pairs and
// resolves one sift-down step per cycle when the sinking node sits here.
// Depends on kmh_pkg.
`timescale 1ns / 1ps

module kmh_cell
    import kmh_pkg::*;
#(
    parameter int LVL    = 0,
    parameter int LEVELS = 8,
    parameter int PW     = 7,
    parameter int NW     = 8
)
(
    input  logic          clk,
    input  logic          rst_n,
    // sinking node handed down from the level above
    input  logic          pass_in_vld,
    input  logic [PW-1:0] pass_in_pos,
    input  node_t         pass_in_node,
    // sift start from the controller
    input  logic          inj_vld,
    input  logic [PW-1:0] inj_pos,
    input  logic          inj_mem,
    input  node_t         inj_node,
    // pair read port (registered data)
    input  logic [PW-1:0] rd_pair,
    output node_t         rd_l,
    output node_t         rd_r,
    // children pair from the level below
    input  node_t         kid_l,
    input  node_t         kid_r,
    input  logic [NW-1:0] live_n,
    // direct node load
    input  logic          ext_we,
    input  logic [PW-1:0] ext_pos,
    input  node_t         ext_node,
    // hand-off to the level below
    output logic          pass_vld,
    output logic [PW-1:0] pass_pos,
    output node_t         pass_node,
    output logic          done,
    output node_t         head
);

    localparam int AW    = (LVL > 1) ? LVL - 1 : 1;
    localparam int DEPTH = 1 << AW;
    localparam int XW    = LEVELS + 1;
    localparam int BASE  = (1 << (LVL + 1)) - 1;

    node_t pair_l_mem [DEPTH];
    node_t pair_r_mem [DEPTH];

    node_t         rd_l_reg;
    node_t         rd_r_reg;
    node_t         head_reg;

    logic          tok_vld_reg;
    logic          tok_vld_next;
    logic [PW-1:0] tok_pos_reg;
    logic [PW-1:0] tok_pos_next;
    logic          tok_mem_reg;
    logic          tok_mem_next;
    node_t         tok_node_reg;
    node_t         tok_node_next;

    node_t         cur;
    logic [XW-1:0] l_idx;
    logic [XW-1:0] r_idx;
    logic          l_ok;
    logic          r_ok;
    logic          go_l;
    logic          go_r;
    logic          moved;

    logic          we;
    logic [PW-1:0] wr_pos;
    node_t         wr_node;
    logic [AW-1:0] wr_idx;
    logic [AW-1:0] rd_idx;

    // token load: hand-off from above wins, else a controller start
    always_comb
    begin
        tok_vld_next  = 1'b0;
        tok_pos_next  = tok_pos_reg;
        tok_mem_next  = tok_mem_reg;
        tok_node_next = tok_node_reg;
        if (pass_in_vld)
        begin
            tok_vld_next  = 1'b1;
            tok_pos_next  = pass_in_pos;
            tok_mem_next  = 1'b0;
            tok_node_next = pass_in_node;
        end
        else if (inj_vld)
        begin
            tok_vld_next  = 1'b1;
            tok_pos_next  = inj_pos;
            tok_mem_next  = inj_mem;
            tok_node_next = inj_node;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_vld_reg <= 1'b0;
        end
        else
        begin
            tok_vld_reg <= tok_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tok_pos_reg  <= tok_pos_next;
        tok_mem_reg  <= tok_mem_next;
        tok_node_reg <= tok_node_next;
    end

    // sift step: strictly smaller child moves up, left wins ties
    always_comb
    begin
        cur   = tok_mem_reg ? (tok_pos_reg[0] ? rd_r_reg : rd_l_reg) : tok_node_reg;
        l_idx = XW'(BASE) + XW'({tok_pos_reg, 1'b0});
        r_idx = l_idx + XW'(1);
        l_ok  = l_idx < XW'(live_n);
        r_ok  = r_idx < XW'(live_n);
        go_l  = l_ok && (kid_l.key < cur.key);
        go_r  = r_ok && (kid_r.key < (go_l ? kid_l.key : cur.key));
        moved = go_l || go_r;
    end

    assign pass_vld  = tok_vld_reg && moved;
    assign pass_pos  = PW'({tok_pos_reg, go_r});
    assign pass_node = cur;
    assign done      = tok_vld_reg && !moved;

    always_comb
    begin
        we      = ext_we || tok_vld_reg;
        wr_pos  = ext_we ? ext_pos : tok_pos_reg;
        if (ext_we)
            wr_node = ext_node;
        else if (go_r)
            wr_node = kid_r;
        else if (go_l)
            wr_node = kid_l;
        else
            wr_node = cur;
        wr_idx  = AW'(wr_pos >> 1);
        rd_idx  = AW'(rd_pair);
    end

    always_ff @(posedge clk)
    begin
        rd_l_reg <= pair_l_mem[rd_idx];
        rd_r_reg <= pair_r_mem[rd_idx];
        if (we && !wr_pos[0])
            pair_l_mem[wr_idx] <= wr_node;
        if (we && wr_pos[0])
            pair_r_mem[wr_idx] <= wr_node;
        // first node of the level; the root for level 0
        if (we && !wr_pos[0] && (wr_idx == '0))
            head_reg <= wr_node;
    end

    assign rd_l = rd_l_reg;
    assign rd_r = rd_r_reg;
    assign head = head_reg;

endmodule

FILE: rtl/core/kway_merge_min_heap_core.sv
// kway_merge_min_heap_core: min-heap selector for a k-way merge.
// Top level: APB register, operation sequencer, one kmh_cell per level.
// Depends on kmh_pkg and kmh_cell.
`timescale 1ns / 1ps

// Usage
//   Command channel: func/slot/new_key/new_way are taken when start is high
//   and busy is low. func WRITE loads one node, BUILD heapifies nodes
//   0..n-1 (n: way_cnt clamped to 1..WAYS), REPLACE puts a new node at
//   the root and sifts it down; the unused code only reports the root.
//   Result channel: done pulses for one cycle with min_key/min_way, the
//   root after the operation. The receiver cannot stall; every item gets
//   exactly one done pulse, in order.
//   Sequence: WRITE and the unused code give done in the cycle after accept.
//   REPLACE: the new node sinks from the root level by level until it
//   settles, then done. BUILD: for each start node, from (n-1)/2 down
//   to 0, a read of the node and its children, then a sift level by
//   level; done follows the last one. Sift speed is set by the level
//   chain, one level per cycle, each level owning a pair-wide memory
//   with a registered read that the level two above addresses ahead
//   of time. busy drops in the done cycle, so the next item may enter there.
//   Reset: way_cnt returns to 128, the sequencer idles. Node storage is
//   not cleared; nodes must be written before they are used.
//   Config: way_cnt at byte address 0, to be written only while idle; the block does not enforce this.

module kway_merge_min_heap_core
    import kmh_pkg::*;
#(
    parameter int WAYS = WAYS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    // APB configuration port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    // command channel
    input  logic              start,
    output logic              busy,
    input  logic [FUNC_W-1:0] func,
    input  logic [SLOT_W-1:0] slot,
    input  logic [KEY_W-1:0]  new_key,
    input  logic [WAY_W-1:0]  new_way,
    // result channel
    output logic              done,
    output logic [KEY_W-1:0]  min_key,
    output logic [WAY_W-1:0]  min_way
);

    localparam int LEVELS = $clog2(WAYS + 1);
    localparam int PW     = (LEVELS > 1) ? LEVELS - 1 : 1;
    localparam int IW     = $clog2(WAYS);
    localparam int NW     = $clog2(WAYS + 1);
    localparam int LVW    = $clog2(LEVELS);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_START = 2'd1;
    localparam logic [1:0] ST_SIFT  = 2'd2;
    localparam logic [1:0] ST_FIN   = 2'd3;

    // level of a 1-based node number: highest set bit
    function automatic logic [LVW-1:0] lvl_of(input logic [IW:0] x);
        logic [LVW-1:0] lv;
        lv = '0;
        for (int b = 0; b <= IW; b++)
        begin
            if (x[b])
                lv = LVW'(b);
        end
        return lv;
    endfunction

    // position within the level: 1-based number without its top bit
    function automatic logic [PW-1:0] pos_of(input logic [IW:0] x,
                                             input logic [LVW-1:0] lv);
        logic [IW:0] y;
        y = x & ~((IW + 1)'(1) << lv);
        return PW'(y);
    endfunction

    // ---------------- configuration register ----------------
    logic [HSIZE_W-1:0] way_cnt_reg;
    logic [NW-1:0]      live_n;
    logic               cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr == ADDR_WAY_CNT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            way_cnt_reg <= WAY_CNT_RST;
        end
        else if (cfg_wr)
        begin
            way_cnt_reg <= pwdata[HSIZE_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr == ADDR_WAY_CNT)
            prdata = APB_DW'(way_cnt_reg);
    end

    // heap size clamped to 1..WAYS
    always_comb
    begin
        if (way_cnt_reg == '0)
            live_n = NW'(1);
        else if (int'(way_cnt_reg) > WAYS)
            live_n = NW'(WAYS);
        else
            live_n = NW'(way_cnt_reg);
    end

    // ---------------- sequencer ----------------
    logic [1:0]    state_reg;
    logic [1:0]    state_next;
    logic          bld_reg;
    logic          bld_next;
    logic [IW-1:0] i_reg;
    logic [IW-1:0] i_next;

    logic          accept;
    logic          done_any;
    logic [LEVELS-1:0] done_vec;

    logic [IW:0]    start_num;
    logic [LVW-1:0] start_lvl;
    logic [PW-1:0]  start_pos;
    logic [IW:0]    wr_num;
    logic [LVW-1:0] wr_lvl;
    logic [PW-1:0]  wr_pos;
    logic           wr_go;

    logic           inj_any;
    logic [LVW-1:0] inj_lvl;
    logic [PW-1:0]  inj_pos;
    logic           inj_mem;
    node_t          inj_node;
    node_t          new_node;

    assign busy     = (state_reg == ST_START) || (state_reg == ST_SIFT);
    assign accept   = start && !busy;
    assign done_any = |done_vec;
    assign new_node = '{key: new_key, way: new_way};

    // node addressing for a build start and for a direct write
    always_comb
    begin
        start_num = (IW + 1)'(i_reg) + (IW + 1)'(1);
        start_lvl = lvl_of(start_num);
        start_pos = pos_of(start_num, start_lvl);
        wr_num    = (IW + 1)'(slot) + (IW + 1)'(1);
        wr_lvl    = lvl_of(wr_num);
        wr_pos    = pos_of(wr_num, wr_lvl);
        wr_go     = accept && (func == FN_WRITE) && (int'(slot) < WAYS);
    end

    // replace starts at the root with the new node; build starts each
    // interior node from storage
    always_comb
    begin
        inj_any  = (accept && (func == FN_REPLACE)) || (state_reg == ST_START);
        inj_mem  = (state_reg == ST_START);
        inj_lvl  = inj_mem ? start_lvl : '0;
        inj_pos  = inj_mem ? start_pos : '0;
        inj_node = new_node;
    end

    always_comb
    begin
        state_next = state_reg;
        bld_next   = bld_reg;
        i_next     = i_reg;
        case (state_reg)
            ST_IDLE, ST_FIN:
            begin
                state_next = ST_IDLE;
                if (accept)
                begin
                    case (func)
                        FN_BUILD:
                        begin
                            bld_next   = 1'b1;
                            i_next     = IW'((live_n - NW'(1)) >> 1);
                            state_next = ST_START;
                        end
                        FN_REPLACE:
                        begin
                            bld_next   = 1'b0;
                            state_next = ST_SIFT;
                        end
                        default:
                        begin
                            state_next = ST_FIN;
                        end
                    endcase
                end
            end
            ST_START:
            begin
                state_next = ST_SIFT;
            end
            ST_SIFT:
            begin
                if (done_any)
                begin
                    if (bld_reg && (i_reg != '0))
                    begin
                        i_next     = i_reg - IW'(1);
                        state_next = ST_START;
                    end
                    else
                    begin
                        state_next = ST_FIN;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            bld_reg   <= 1'b0;
            i_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            bld_reg   <= bld_next;
            i_reg     <= i_next;
        end
    end

    // ---------------- level chain ----------------
    node_t         rd_l_w    [LEVELS];
    node_t         rd_r_w    [LEVELS];
    node_t         head_w    [LEVELS];
    logic          pass_vld_w[LEVELS];
    logic [PW-1:0] pass_pos_w[LEVELS];
    node_t         pass_node_w[LEVELS];
    logic [PW-1:0] rd_pair_w [LEVELS];

    for (genvar g = 0; g < LEVELS; g++)
    begin : g_lvl
        logic          in_vld;
        logic [PW-1:0] in_pos;
        node_t         in_node;
        node_t         kl;
        node_t         kr;
        logic          lv_inj;
        logic          lv_we;

        // read address: self read or children read of a build start,
        // else the child position chosen two levels up, or zero on levels 0 and 1
        if (g >= 2)
        begin : g_rd_far
            always_comb
            begin
                if ((state_reg == ST_START) && (start_lvl == LVW'(g)))
                    rd_pair_w[g] = start_pos >> 1;
                else if ((state_reg == ST_START) &&
                         (({1'b0, start_lvl} + (LVW + 1)'(1)) == (LVW + 1)'(g)))
                    rd_pair_w[g] = start_pos;
                else
                    rd_pair_w[g] = pass_pos_w[g-2];
            end
        end
        else
        begin : g_rd_near
            always_comb
            begin
                if ((state_reg == ST_START) && (start_lvl == LVW'(g)))
                    rd_pair_w[g] = start_pos >> 1;
                else if ((state_reg == ST_START) &&
                         (({1'b0, start_lvl} + (LVW + 1)'(1)) == (LVW + 1)'(g)))
                    rd_pair_w[g] = start_pos;
                else
                    rd_pair_w[g] = '0;
            end
        end

        if (g == 0)
        begin : g_top
            assign in_vld  = 1'b0;
            assign in_pos  = '0;
            assign in_node = '0;
        end
        else
        begin : g_mid
            assign in_vld  = pass_vld_w[g-1];
            assign in_pos  = pass_pos_w[g-1];
            assign in_node = pass_node_w[g-1];
        end

        if (g == LEVELS - 1)
        begin : g_leaf
            assign kl = '0;
            assign kr = '0;
        end
        else
        begin : g_inner
            assign kl = rd_l_w[g+1];
            assign kr = rd_r_w[g+1];
        end

        assign lv_inj = inj_any && (inj_lvl == LVW'(g));
        assign lv_we  = wr_go && (wr_lvl == LVW'(g));

        kmh_cell #(
            .LVL    (g),
            .LEVELS (LEVELS),
            .PW     (PW),
            .NW     (NW)
        ) u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .pass_in_vld  (in_vld),
            .pass_in_pos  (in_pos),
            .pass_in_node (in_node),
            .inj_vld      (lv_inj),
            .inj_pos      (inj_pos),
            .inj_mem      (inj_mem),
            .inj_node     (inj_node),
            .rd_pair      (rd_pair_w[g]),
            .rd_l         (rd_l_w[g]),
            .rd_r         (rd_r_w[g]),
            .kid_l        (kl),
            .kid_r        (kr),
            .live_n       (live_n),
            .ext_we       (lv_we),
            .ext_pos      (wr_pos),
            .ext_node     (new_node),
            .pass_vld     (pass_vld_w[g]),
            .pass_pos     (pass_pos_w[g]),
            .pass_node    (pass_node_w[g]),
            .done         (done_vec[g]),
            .head         (head_w[g])
        );
    end

    // ---------------- result ----------------
    assign done    = (state_reg == ST_FIN);
    assign min_key = head_w[0].key;
    assign min_way = head_w[0].way;

endmodule

FILE: bench/heap_root_checker.sv
`timescale 1ns / 1ps
// heap_root_checker: watches the command, result and APB channels of the merge heap core,
// keeps its own heap image, predicts the root after every command and compares it.
// Depends on kmh_pkg.

module heap_root_checker
    import kmh_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic              pready,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    input  logic              start,
    input  logic              busy,
    input  logic [FUNC_W-1:0] func,
    input  logic [SLOT_W-1:0] slot,
    input  logic [KEY_W-1:0]  new_key,
    input  logic [WAY_W-1:0]  new_way,
    input  logic              done,
    input  logic [KEY_W-1:0]  min_key,
    input  logic [WAY_W-1:0]  min_way,
    output int                mismatches,
    output int                pending
);

    node_t              heap_node [WAYS_DEF];
    logic [HSIZE_W-1:0] size_reg;
    node_t              root_q [$];
    int                 fails;

    // 0 acts as 1, anything past the way count as the way count
    function automatic int nodes_in_use();
        if (size_reg == 0)
            return 1;
        if (size_reg > WAYS_DEF)
            return WAYS_DEF;
        return int'(size_reg);
    endfunction

    // move down only on a strictly smaller child, left wins a tie
    function automatic void sink(int at, int n);
        int    pick;
        node_t tmp;
        bit    settled;
        settled = 1'b0;
        while (at < n && !settled)
        begin
            pick = at;
            if (2 * at + 1 < n && heap_node[2 * at + 1].key < heap_node[pick].key)
                pick = 2 * at + 1;
            if (2 * at + 2 < n && heap_node[2 * at + 2].key < heap_node[pick].key)
                pick = 2 * at + 2;
            if (pick == at)
                settled = 1'b1;
            else
            begin
                tmp             = heap_node[at];
                heap_node[at]   = heap_node[pick];
                heap_node[pick] = tmp;
                at              = pick;
            end
        end
    endfunction

    function automatic node_t root_after(logic [FUNC_W-1:0] f, logic [SLOT_W-1:0] s,
                                         node_t nd);
        int n;
        n = nodes_in_use();
        case (f)
            FN_WRITE:   heap_node[s] = nd;   // slot width never exceeds storage
            FN_BUILD:   for (int i = (n - 1) / 2; i >= 0; i--) sink(i, n);
            FN_REPLACE:
            begin
                heap_node[0] = nd;
                sink(0, n);
            end
            default:    ;
        endcase
        return heap_node[0];
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        node_t want;
        node_t cmd_node;
        if (!rst_n)
        begin
            for (int i = 0; i < WAYS_DEF; i++)
                heap_node[i] = '0;
            size_reg = WAY_CNT_RST;
            root_q.delete();
            fails = 0;
            mismatches <= 0;
            pending <= 0;
        end
        else
        begin
            if (done)
            begin
                if (root_q.size() == 0)
                begin
                    $error("unexpected result: min_key %h min_way %h", min_key, min_way);
                    fails++;
                end
                else
                begin
                    want = root_q.pop_front();
                    if (min_key !== want.key)
                    begin
                        $error("min_key: expected %h, got %h", want.key, min_key);
                        fails++;
                    end
                    if (min_way !== want.way)
                    begin
                        $error("min_way: expected %h, got %h", want.way, min_way);
                        fails++;
                    end
                end
            end
            if (start && !busy)
            begin
                cmd_node.key = new_key;
                cmd_node.way = new_way;
                root_q.push_back(root_after(func, slot, cmd_node));
            end
            if (psel && penable && pwrite && pready && paddr == ADDR_WAY_CNT)
                size_reg = pwdata[HSIZE_W-1:0];
            mismatches <= fails;
            pending <= root_q.size();
        end
    end

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
// tb_top: stimulus and verdict for kway_merge_min_heap_core.
// Depends on kmh_pkg, the core RTL and heap_root_checker.

module tb_top;
    import kmh_pkg::*;

    // unused command code: reports the root, touches nothing
    localparam logic [FUNC_W-1:0] FN_PEEK = 2'd3;

    localparam int N_PHASES    = 9;
    localparam int PHASE_ITEMS = 57;     // ~600 items in all with the directed part
    localparam int STALL_LIMIT = 20000;  // longer than a full 128-node build
    localparam int TAIL_CYCLES = 20;     // longer than a replace sift

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [APB_AW-1:0] paddr = '0;
    logic [APB_DW-1:0] pwdata = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;
    logic              start = 1'b0;
    logic              busy;
    logic [FUNC_W-1:0] func = '0;
    logic [SLOT_W-1:0] slot = '0;
    logic [KEY_W-1:0]  new_key = '0;
    logic [WAY_W-1:0]  new_way = '0;
    logic              done;
    logic [KEY_W-1:0]  min_key;
    logic [WAY_W-1:0]  min_way;

    int check_fails;
    int check_pending;

    int idle_pct = 0;       // sender idle chance per item, percent
    int cmds_sent = 0;
    int roots_seen = 0;
    int sizes_used = 0;
    int stall_cycles = 0;

    // slots written so far; build and replace only ever read slots below the
    // live size, and every command reads slot 0, so those get loaded first
    bit slot_loaded [WAYS_DEF];

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    kway_merge_min_heap_core DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .start   (start),
        .busy    (busy),
        .func    (func),
        .slot    (slot),
        .new_key (new_key),
        .new_way (new_way),
        .done    (done),
        .min_key (min_key),
        .min_way (min_way)
    );

    heap_root_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .pready     (pready),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .start      (start),
        .busy       (busy),
        .func       (func),
        .slot       (slot),
        .new_key    (new_key),
        .new_way    (new_way),
        .done       (done),
        .min_key    (min_key),
        .min_way    (min_way),
        .mismatches (check_fails),
        .pending    (check_pending)
    );

    // watchdog: any handshake on any port restarts the count
    always @(posedge clk)
    begin
        if (done)
            roots_seen <= roots_seen + 1;
        if (!rst_n || (start && !busy) || done || (psel && penable))
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
            $display("FAILURE");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    // keys lean toward zero, the all-ones sentinel and a narrow band for ties
    function automatic logic [KEY_W-1:0] pick_key();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2, 3:    return KEY_W'($urandom_range(0, 15));
            default: return $urandom;
        endcase
    endfunction

    function automatic int live_nodes(logic [HSIZE_W-1:0] v);
        if (v == 0)
            return 1;
        if (v > WAYS_DEF)
            return WAYS_DEF;
        return int'(v);
    endfunction

    // one command; start stays high across back-to-back items
    task automatic issue(logic [FUNC_W-1:0] f, logic [SLOT_W-1:0] s,
                         logic [KEY_W-1:0] k, logic [WAY_W-1:0] w);
        if ($urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            do @(posedge clk); while ($urandom_range(0, 99) < idle_pct);
        end
        start   <= 1'b1;
        func    <= f;
        slot    <= s;
        new_key <= k;
        new_way <= w;
        do @(posedge clk); while (busy);
        if (f == FN_WRITE)
            slot_loaded[s] = 1'b1;
        cmds_sent++;
    endtask

    // stop issuing and wait until every root has come back
    task automatic drain();
        start <= 1'b0;
        do @(posedge clk); while (check_pending != 0);
    endtask

    // the way count is the only register; upper data bits are random don't-cares
    task automatic set_way_cnt(logic [HSIZE_W-1:0] v);
        logic [APB_DW-1:0] wdata;
        drain();
        wdata = $urandom;
        wdata[HSIZE_W-1:0] = v;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_WAY_CNT;
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sizes_used++;
    endtask

    // load a fresh run head for the low slots plus any never-written live slot
    task automatic load_heads(int n);
        for (int i = 0; i < n; i++)
            if (i < 16 || !slot_loaded[i])
                issue(FN_WRITE, SLOT_W'(i), pick_key(), WAY_W'($urandom_range(0, 127)));
    endtask

    initial
    begin
        logic [HSIZE_W-1:0] size_val;
        int                 n;
        int                 phase_end;
        int                 r;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- directed part ----
        // three-node heap: sentinel, zero key, ties on the children
        set_way_cnt(8'd3);
        issue(FN_WRITE, 7'd0, 32'hFFFF_FFFF, 7'h7F);
        issue(FN_WRITE, 7'd1, 32'h0000_0000, 7'h00);
        issue(FN_WRITE, 7'd2, 32'h0000_0005, 7'h2A);
        issue(FN_BUILD, 7'd0, 32'h0, 7'h0);
        issue(FN_REPLACE, 7'd0, 32'hFFFF_FFFF, 7'h01);   // sentinel sinks
        issue(FN_REPLACE, 7'd0, 32'h0000_0005, 7'h03);   // smaller than both children: stays
        issue(FN_WRITE, 7'd1, 32'h0000_0009, 7'h11);
        issue(FN_WRITE, 7'd2, 32'h0000_0009, 7'h12);
        issue(FN_REPLACE, 7'd0, 32'h0000_000A, 7'h05);   // equal children: left wins
        issue(FN_PEEK, 7'h7F, 32'hDEAD_BEEF, 7'h7F);
        issue(FN_WRITE, 7'h7F, 32'h5A5A_5A5A, 7'h55);    // top slot, outside the heap
        issue(FN_WRITE, 7'd0, 32'h0000_0000, 7'h00);
        // single node heap: build and sift change nothing
        set_way_cnt(8'd1);
        issue(FN_BUILD, 7'd0, 32'h0, 7'h0);
        issue(FN_REPLACE, 7'd0, 32'h0000_007B, 7'h7F);
        // size 0 behaves as 1
        set_way_cnt(8'd0);
        issue(FN_REPLACE, 7'd0, 32'h0000_0000, 7'h00);
        issue(FN_BUILD, 7'h55, 32'hFFFF_FFFF, 7'h2A);
        // two nodes
        set_way_cnt(8'd2);
        issue(FN_WRITE, 7'd1, 32'h0000_0000, 7'h0F);
        issue(FN_REPLACE, 7'd0, 32'hFFFF_FFFF, 7'h70);
        issue(FN_BUILD, 7'd0, 32'h0, 7'h0);

        // ---- random merge sessions ----
        // each phase: new size, load run heads, build, then mostly replaces
        // as a merge would do, with stray writes, rebuilds and peeks mixed in
        for (int p = 0; p < N_PHASES; p++)
        begin
            idle_pct = (p < 3) ? 14 : (p < 6) ? 80 : 0;
            case (p)
                0:       size_val = 8'd128;
                1:       size_val = 8'd2;
                2:       size_val = 8'd255;
                3:       size_val = HSIZE_W'($urandom_range(3, 31));
                4:       size_val = 8'd1;
                5:       size_val = 8'd0;
                6:       size_val = 8'd129;
                7:       size_val = HSIZE_W'($urandom_range(1, 128));
                default: size_val = 8'd7;
            endcase
            set_way_cnt(size_val);
            n = live_nodes(size_val);
            phase_end = cmds_sent + PHASE_ITEMS;
            load_heads(n);
            issue(FN_BUILD, SLOT_W'($urandom), pick_key(), WAY_W'($urandom));
            while (cmds_sent < phase_end)
            begin
                r = $urandom_range(0, 99);
                if (r < 70)
                    issue(FN_REPLACE, SLOT_W'($urandom), pick_key(), WAY_W'($urandom));
                else if (r < 80)
                    issue(FN_WRITE, SLOT_W'($urandom), pick_key(), WAY_W'($urandom));
                else if (r < 88)
                    issue(FN_BUILD, SLOT_W'($urandom), pick_key(), WAY_W'($urandom));
                else
                    issue(FN_PEEK, SLOT_W'($urandom), pick_key(), WAY_W'($urandom));
            end
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Covered %0d commands and %0d returned roots over %0d heap sizes,",
                 cmds_sent, roots_seen, sizes_used);
        $display("sizes 0, 1, 2 and past the way count, sender idle 14%%, 80%% and none.");
        if (check_fails == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/core/kmh_pkg.sv
rtl/core/kmh_cell.sv
rtl/core/kway_merge_min_heap_core.sv
bench/heap_root_checker.sv
bench/tb_top.sv
